/* rtl/core/arsmm_pkg.sv */
package arsmm_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 26;
  localparam int CNT_W = 16;
  localparam int IC_W = 11;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH = 4;
  localparam int RES_DEPTH = 4;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd3;

  typedef struct packed {
    logic             first;
    logic             emit;
    logic             done;
    logic [IDX_W-1:0] out_idx;
  } arsmm_ctrl_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             done;
  } arsmm_res_t;

endpackage

/* rtl/core/arsmm_ram.sv */
module arsmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/arsmm_fifo.sv */
module arsmm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/arsmm_front.sv */
module arsmm_front #(
  parameter int INNER_DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  input  logic [arsmm_pkg::CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [arsmm_pkg::CFG_DATA_W-1:0]              cfg_data_i,
  input  logic                                          push_i,
  input  logic signed [arsmm_pkg::VAL_W-1:0]            element_value_i,
  input  logic                                          item_full_i,
  output logic                                          item_push_o,
  output arsmm_pkg::arsmm_ctrl_t                        item_ctrl_o,
  output logic [(INNER_DEPTH > 1 ? $clog2(INNER_DEPTH) : 1)-1:0] item_slot_o,
  output logic [DATA_WIDTH-1:0]                         item_value_o,
  output logic [arsmm_pkg::MODE_W-1:0]                  mode_o
);

  import arsmm_pkg::*;

  localparam int AW = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;

  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  outer_cnt_q, axis_len_q;
  logic [IC_W-1:0]   inner_cnt_q;

  logic [IC_W-1:0]   inner_q;
  logic [CNT_W-1:0]  axis_q, outer_q;
  logic [IDX_W-1:0]  oidx_q;

  logic [IC_W-1:0]   ic_last;
  logic [CNT_W-1:0]  al_last, oc_last;
  logic              accept, inner_wrap, axis_wrap, emit, done;

  always_comb begin
    if (inner_cnt_q == '0) begin
      ic_last = '0;
    end else if (int'(inner_cnt_q) > INNER_DEPTH) begin
      ic_last = IC_W'(INNER_DEPTH - 1);
    end else begin
      ic_last = inner_cnt_q - 1'b1;
    end
    al_last = (axis_len_q == '0) ? '0 : axis_len_q - 1'b1;
    oc_last = (outer_cnt_q == '0) ? '0 : outer_cnt_q - 1'b1;
  end

  assign accept     = push_i && !item_full_i;
  assign inner_wrap = (inner_q == ic_last);
  assign axis_wrap  = (axis_q == al_last);
  assign emit       = axis_wrap;
  assign done       = emit && (outer_q == oc_last) && inner_wrap;

  assign item_push_o          = accept;
  assign item_ctrl_o.first    = (axis_q == '0);
  assign item_ctrl_o.emit     = emit;
  assign item_ctrl_o.done     = done;
  assign item_ctrl_o.out_idx  = oidx_q;
  assign item_slot_o          = AW'(inner_q);
  assign item_value_o         = DATA_WIDTH'(element_value_i);
  assign mode_o               = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SUM;
      outer_cnt_q <= CNT_W'(1);
      axis_len_q  <= CNT_W'(1);
      inner_cnt_q <= IC_W'(1);
      inner_q     <= '0;
      axis_q      <= '0;
      outer_q     <= '0;
      oidx_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_OUTER: outer_cnt_q <= cfg_data_i;
        REG_AXIS:  axis_len_q  <= cfg_data_i;
        REG_INNER: inner_cnt_q <= cfg_data_i[IC_W-1:0];
        default:   mode_q      <= mode_q;
      endcase
      inner_q <= '0;
      axis_q  <= '0;
      outer_q <= '0;
      oidx_q  <= '0;
    end else if (accept) begin
      if (inner_wrap) begin
        inner_q <= '0;
        if (axis_wrap) begin
          axis_q  <= '0;
          outer_q <= (outer_q == oc_last) ? '0 : outer_q + 1'b1;
        end else begin
          axis_q <= axis_q + 1'b1;
        end
      end else begin
        inner_q <= inner_q + 1'b1;
      end
      if (emit) begin
        oidx_q <= done ? '0 : oidx_q + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/arsmm_back.sv */
module arsmm_back #(
  parameter int INNER_DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [arsmm_pkg::MODE_W-1:0]                  mode_i,
  input  logic                                          item_empty_i,
  input  arsmm_pkg::arsmm_ctrl_t                        item_ctrl_i,
  input  logic [(INNER_DEPTH > 1 ? $clog2(INNER_DEPTH) : 1)-1:0] item_slot_i,
  input  logic [DATA_WIDTH-1:0]                         item_value_i,
  output logic                                          item_pop_o,
  input  logic [arsmm_pkg::RES_CNT_W-1:0]               res_count_i,
  output logic                                          res_push_o,
  output arsmm_pkg::arsmm_res_t                         res_o
);

  import arsmm_pkg::*;

  localparam int AW = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;

  logic                  issue;
  logic                  s1_vld_q;
  arsmm_ctrl_t           s1_ctrl_q;
  logic [AW-1:0]         s1_slot_q;
  logic [DATA_WIDTH-1:0] s1_x_q;
  logic                  fwd_hit_q;
  logic [DATA_WIDTH-1:0] fwd_val_q;
  logic [DATA_WIDTH-1:0] rdata, old_val, acc;

  assign issue      = !item_empty_i && (res_count_i <= RES_CNT_W'(RES_DEPTH - 2));
  assign item_pop_o = issue;

  arsmm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(INNER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_slot_q),
    .wdata_i(acc),
    .raddr_i(item_slot_i),
    .rdata_o(rdata)
  );

  // bypass the word still being written when the same slot follows directly
  assign old_val = fwd_hit_q ? fwd_val_q : rdata;

  always_comb begin
    if (s1_ctrl_q.first) begin
      acc = s1_x_q;
    end else begin
      case (mode_i)
        MODE_MAX: acc = ($signed(s1_x_q) > $signed(old_val)) ? s1_x_q : old_val;
        MODE_MIN: acc = ($signed(old_val) > $signed(s1_x_q)) ? s1_x_q : old_val;
        default:  acc = old_val + s1_x_q;
      endcase
    end
  end

  assign res_push_o  = s1_vld_q && s1_ctrl_q.emit;
  assign res_o.value = VAL_W'(acc);
  assign res_o.index = s1_ctrl_q.out_idx;
  assign res_o.done  = s1_ctrl_q.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ctrl_q <= item_ctrl_i;
      s1_slot_q <= item_slot_i;
      s1_x_q    <= item_value_i;
      fwd_hit_q <= s1_vld_q && (s1_slot_q == item_slot_i);
      fwd_val_q <= acc;
    end
  end

endmodule

/* rtl/core/axis_reduction_sum_max_min.sv */
// Reduces a row-major array of outer_count x axis_length x inner_count signed words along
// the middle axis by sum (wrapping), maximum or minimum; registers 0..3 are mode, outer
// count, axis length and inner count, and any register write restarts the array. One word
// is taken per cycle unless the input stalls: each word needs one read and one write of the partial
// store, a single two-port memory of INNER_DEPTH words, and a bypass covers the same slot
// arriving on consecutive cycles. A word of the last slice passes the input queue, the
// accumulate register and the result queue before its result shows on the result ports. The input
// stalls only when the result side holds three or four words unread and the four-word input
// queue has filled behind it. The store needs no clearing pass since the first slice seeds it.
module axis_reduction_sum_max_min #(
  parameter int INNER_DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [arsmm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [arsmm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic signed [arsmm_pkg::VAL_W-1:0]    element_value_i,
  output logic                                  empty_o,
  input  logic                                  pop_i,
  output logic signed [arsmm_pkg::VAL_W-1:0]    reduced_value_o,
  output logic [arsmm_pkg::IDX_W-1:0]           output_index_o,
  output logic                                  array_done_o
);

  import arsmm_pkg::*;

  localparam int AW = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
  localparam int CTRL_W = $bits(arsmm_ctrl_t);
  localparam int QW = CTRL_W + AW + DATA_WIDTH;
  localparam int RW = $bits(arsmm_res_t);

  logic                  f_push, q_full, q_empty, b_pop;
  arsmm_ctrl_t           f_ctrl, b_ctrl;
  logic [AW-1:0]         f_slot, b_slot;
  logic [DATA_WIDTH-1:0] f_value, b_value;
  logic [QW-1:0]         q_head;
  logic [MODE_W-1:0]     mode;
  logic                  res_push;
  arsmm_res_t            res_in, res_out;
  logic [RW-1:0]         res_head;
  logic [RES_CNT_W-1:0]  res_count;
  logic                  res_full;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full;

  arsmm_front #(
    .INNER_DEPTH(INNER_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .element_value_i(element_value_i),
    .item_full_i    (q_full),
    .item_push_o    (f_push),
    .item_ctrl_o    (f_ctrl),
    .item_slot_o    (f_slot),
    .item_value_o   (f_value),
    .mode_o         (mode)
  );

  arsmm_fifo #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i ({f_ctrl, f_slot, f_value}),
    .pop_i  (b_pop),
    .data_o (q_head),
    .full_o (q_full),
    .empty_o(q_empty),
    .count_o()
  );

  assign {b_ctrl, b_slot, b_value} = q_head;

  arsmm_back #(
    .INNER_DEPTH(INNER_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode),
    .item_empty_i(q_empty),
    .item_ctrl_i (b_ctrl),
    .item_slot_i (b_slot),
    .item_value_i(b_value),
    .item_pop_o  (b_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  arsmm_fifo #(
    .WIDTH(RW),
    .DEPTH(RES_DEPTH)
  ) u_results (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .pop_i  (pop_i),
    .data_o (res_head),
    .full_o (res_full),
    .empty_o(empty_o),
    .count_o(res_count)
  );

  assign res_out         = res_head;
  // room is reserved at issue, so the result queue never refuses a word
  assign reduced_value_o = res_full ? res_out.value : res_out.value;
  assign output_index_o  = res_out.index;
  assign array_done_o    = res_out.done;

endmodule

/* sim/axis_reduction_sum_max_min_tb.sv */
`timescale 1ns / 100ps

module axis_reduction_sum_max_min_tb;
  import arsmm_pkg::*;

  localparam int INNER_DEPTH = 1024;
  localparam int STALL_CYCLES = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push_i = 1'b0;
  logic                  full_o;
  logic signed [VAL_W-1:0] element_value_i = '0;
  logic                  empty_o;
  logic                  pop_i = 1'b0;
  logic signed [VAL_W-1:0] reduced_value_o;
  logic [IDX_W-1:0]      output_index_o;
  logic                  array_done_o;

  int send_idle_pct = 27;
  int recv_idle_pct = 77;
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;
  int err_count = 0;
  int idle_cycles = 0;

  // reduction state kept by the testbench
  logic [MODE_W-1:0]     cur_mode = MODE_SUM;
  logic [CNT_W-1:0]      cur_outer = CNT_W'(1);
  logic [CNT_W-1:0]      cur_axis = CNT_W'(1);
  logic [IC_W-1:0]       cur_inner = IC_W'(1);
  int unsigned           axis_pos = 0;
  int unsigned           inner_pos = 0;
  int unsigned           outer_pos = 0;
  logic signed [VAL_W-1:0] partial_acc [INNER_DEPTH];
  arsmm_res_t            pending_results [$];

  int unsigned             eff_outer, eff_axis, eff_inner;
  logic signed [VAL_W-1:0] acc_word;
  arsmm_res_t              next_result;
  arsmm_res_t              exp_result;

  axis_reduction_sum_max_min #(
    .INNER_DEPTH(INNER_DEPTH),
    .DATA_WIDTH (VAL_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .element_value_i(element_value_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .reduced_value_o(reduced_value_o),
    .output_index_o (output_index_o),
    .array_done_o   (array_done_o)
  );

  always #10 clk_i = ~clk_i;

  // register writes and accepted words update the expected state
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE:  cur_mode = cfg_data_i[MODE_W-1:0];
          REG_OUTER: cur_outer = cfg_data_i;
          REG_AXIS:  cur_axis = cfg_data_i;
          REG_INNER: cur_inner = cfg_data_i[IC_W-1:0];
          default: ;
        endcase
        axis_pos = 0;
        inner_pos = 0;
        outer_pos = 0;
      end
      if (push_i && !full_o) begin
        eff_outer = (cur_outer == 0) ? 1 : cur_outer;
        eff_axis = (cur_axis == 0) ? 1 : cur_axis;
        eff_inner = (cur_inner == 0) ? 1 :
                    (cur_inner > INNER_DEPTH) ? INNER_DEPTH : cur_inner;
        if (inner_pos >= eff_inner) inner_pos = 0;
        if (axis_pos >= eff_axis) axis_pos = 0;
        if (outer_pos >= eff_outer) outer_pos = 0;
        if (axis_pos == 0) begin
          acc_word = element_value_i;
        end else begin
          case (cur_mode)
            MODE_MAX: acc_word = (element_value_i > partial_acc[inner_pos]) ?
                                 element_value_i : partial_acc[inner_pos];
            MODE_MIN: acc_word = (element_value_i < partial_acc[inner_pos]) ?
                                 element_value_i : partial_acc[inner_pos];
            default:  acc_word = partial_acc[inner_pos] + element_value_i;
          endcase
        end
        partial_acc[inner_pos] = acc_word;
        if (axis_pos == eff_axis - 1) begin
          next_result.value = acc_word;
          next_result.index = IDX_W'(outer_pos * eff_inner + inner_pos);
          next_result.done = (outer_pos == eff_outer - 1) && (inner_pos == eff_inner - 1);
          pending_results.push_back(next_result);
        end
        inner_pos++;
        if (inner_pos >= eff_inner) begin
          inner_pos = 0;
          axis_pos++;
          if (axis_pos >= eff_axis) begin
            axis_pos = 0;
            outer_pos++;
            if (outer_pos >= eff_outer) outer_pos = 0;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result word: value %h index %0d done %0d",
                   reduced_value_o, output_index_o, array_done_o);
      end else begin
        exp_result = pending_results.pop_front();
        if (reduced_value_o !== exp_result.value || output_index_o !== exp_result.index ||
            array_done_o !== exp_result.done) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected value %h index %0d done %0d, got %h %0d %0d",
                     exp_result.value, exp_result.index, exp_result.done,
                     reduced_value_o, output_index_o, array_done_o);
        end
      end
    end
  end

  // receiver with random stalls and an on-demand long hold-off
  always @(posedge clk_i) begin
    if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      stall_left <= STALL_CYCLES;
      pop_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("axis_reduction_sum_max_min test failed");
        $finish;
      end
    end
  end

  task automatic push_element(input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (full_o);
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] mode_w, input logic [CFG_DATA_W-1:0] outer_w,
                           input logic [CFG_DATA_W-1:0] axis_w, input logic [CFG_DATA_W-1:0] inner_w);
    wait_drained();
    write_reg(REG_MODE, mode_w, 1'b0);
    write_reg(REG_OUTER, outer_w, 1'b0);
    write_reg(REG_AXIS, axis_w, 1'b0);
    write_reg(REG_INNER, inner_w, 1'b1);
  endtask

  function automatic logic [VAL_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_value_extremes();
    configure(CFG_DATA_W'(MODE_SUM), 16'd1, 16'd1, 16'd1);
    push_element(32'h8000_0000);
    push_element(32'h7fff_ffff);
    push_element(32'hffff_ffff);
    push_element(32'h0000_0000);
  endtask

  task automatic test_modes();
    logic [MODE_W-1:0] mode_list [4];
    mode_list = '{MODE_SUM, MODE_MAX, MODE_MIN, MODE_UNUSED};
    foreach (mode_list[m]) begin
      configure(CFG_DATA_W'(mode_list[m]), 16'd1, 16'd2, 16'd2);
      push_element(32'h7fff_ffff);
      push_element(32'h8000_0000);
      push_element(32'h0000_0001);
      push_element(32'hffff_ffff);
    end
  endtask

  task automatic test_zero_counts();
    configure(CFG_DATA_W'(MODE_SUM), 16'd0, 16'd0, 16'd0);
    push_element(32'h1234_5678);
    push_element(32'hfedc_ba98);
  endtask

  // oversized inner count, then a single write in mid-array restarts it
  task automatic test_restart();
    configure(CFG_DATA_W'(MODE_MAX), 16'd1, 16'd2, 16'd2047);
    repeat (3) push_element(pick_element());
    wait_drained();
    write_reg(REG_AXIS, 16'd1, 1'b1);
    push_element(pick_element());
  endtask

  task automatic test_large_shapes();
    configure(CFG_DATA_W'(MODE_MAX), 16'hffff, 16'd1, 16'd1024);
    repeat (40) push_element(pick_element());
    configure(CFG_DATA_W'(MODE_MIN), 16'd1, 16'hffff, 16'hffff);
    repeat (15) push_element(pick_element());
    configure(CFG_DATA_W'(MODE_SUM), 16'hffff, 16'hffff, 16'd1);
    repeat (15) push_element(pick_element());
  endtask

  task automatic test_backpressure();
    configure(CFG_DATA_W'(MODE_SUM), 16'd3, 16'd1, 16'd4);
    stall_req++;
    repeat (40) push_element(pick_element());
  endtask

  task automatic random_shape(output int unsigned sent);
    logic [CFG_DATA_W-1:0] mode_w, outer_w, axis_w, inner_w;
    int unsigned oc, al, ic, full_len, n;
    mode_w = 16'($urandom);
    if ($urandom_range(7) != 0) mode_w[MODE_W-1:0] = MODE_W'($urandom_range(2));
    outer_w = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
    axis_w = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
    case ($urandom_range(19))
      0: inner_w = 16'd0;
      1: inner_w = 16'($urandom_range(1000, 2047));
      default: inner_w = 16'($urandom_range(1, 8));
    endcase
    oc = (outer_w == 0) ? 1 : outer_w;
    al = (axis_w == 0) ? 1 : axis_w;
    ic = (inner_w[IC_W-1:0] == 0) ? 1 :
         (inner_w[IC_W-1:0] > INNER_DEPTH) ? INNER_DEPTH : inner_w[IC_W-1:0];
    full_len = oc * al * ic;
    if (full_len <= 64)
      n = ($urandom_range(5) == 0) ? $urandom_range(1, full_len) :
          full_len * $urandom_range(1, 2);
    else
      n = $urandom_range(10, 60);
    configure(mode_w, outer_w, axis_w, inner_w);
    repeat (n) push_element(pick_element());
    sent = n;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned total, n;
    total = 0;
    while (total < target) begin
      random_shape(n);
      total += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_value_extremes();
    test_modes();
    test_zero_counts();
    test_restart();
    test_large_shapes();
    run_random(400);
    send_idle_pct = 77;
    recv_idle_pct = 27;
    run_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    run_random(340);
    wait_drained();
    if (err_count == 0) begin
      $display("axis_reduction_sum_max_min test passed");
    end else begin
      $display("axis_reduction_sum_max_min test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/arsmm_pkg.sv
rtl/core/arsmm_ram.sv
rtl/core/arsmm_fifo.sv
rtl/core/arsmm_front.sv
rtl/core/arsmm_back.sv
rtl/core/axis_reduction_sum_max_min.sv
sim/axis_reduction_sum_max_min_tb.sv
